### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the metric Gram-Schmidt core.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed in metric Gram-Schmidt core");

// Antecedent implies consequent in the next cycle.
`define MGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed in metric Gram-Schmidt core");

`endif

### hdl/mgs_pkg.sv
// Package of the metric Gram-Schmidt core: sizes, codes, types and helpers.
// Depends on nothing; used by every module of the block.
`default_nettype none
package mgs_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 16;
  localparam int FRAC_BITS = 24;
  localparam int DW        = 32;
  localparam int RA_W      = $clog2(MAX_ROWS);
  localparam int CA_W      = $clog2(MAX_COLS);
  localparam int SA_W      = 2 * RA_W;
  localparam int XA_W      = RA_W + CA_W;
  localparam int PROD_W    = 2 * DW - FRAC_BITS;
  localparam int ACC_W     = 48;
  localparam int NUM_W     = DW + FRAC_BITS;
  localparam int ROOT_W    = NUM_W / 2;
  localparam int CNT_W     = $clog2(NUM_W);

  typedef enum logic [1:0] {
    ACT_WR_S = 2'd0,
    ACT_WR_X = 2'd1,
    ACT_RUN  = 2'd2,
    ACT_RD_X = 2'd3
  } action_t;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SAT = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } cval_t;

  typedef struct packed {
    logic                 ovf;
    logic signed [DW-1:0] val;
  } sat_t;

  typedef enum logic [1:0] {
    ACC_S_RE,
    ACC_S_IM,
    ACC_A_RE,
    ACC_A_IM
  } acc_sel_t;

  typedef struct packed {
    logic     valid;
    acc_sel_t sel;
    logic     neg;
  } acc_ctl_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } rd_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_COL,
    ST_D_ROW, ST_D_RD, ST_D_MUL, ST_D_DRN, ST_D_SAT, ST_D_OUT, ST_D_DRN2, ST_D_FIN,
    ST_U_RDP, ST_U_RDC, ST_U_LD, ST_U_MUL, ST_U_DRN, ST_U_WR,
    ST_N_SQS, ST_N_SQW, ST_N_RD, ST_N_LD, ST_N_SRE, ST_N_WRE, ST_N_SIM, ST_N_WIM,
    ST_DONE
  } seq_state_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sh8000_0000);
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(64'h8000_0000);
  localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'(64'h7FFF_FFFF);

  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[DW-1:0];
    if (v > ACC_MAX) begin
      s.ovf = 1'b1;
      s.val = {1'b0, {(DW-1){1'b1}}};
    end else if (v < ACC_MIN) begin
      s.ovf = 1'b1;
      s.val = {1'b1, {(DW-1){1'b0}}};
    end
    return s;
  endfunction

  function automatic sat_t div_sat(input logic neg, input logic [NUM_W-1:0] q);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      s.val = -q[DW-1:0];
      if (q > Q_NEG_LIM) begin
        s.ovf = 1'b1;
        s.val = {1'b1, {(DW-1){1'b0}}};
      end
    end else begin
      s.val = q[DW-1:0];
      if (q > Q_POS_LIM) begin
        s.ovf = 1'b1;
        s.val = {1'b0, {(DW-1){1'b1}}};
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### hdl/mgs_mul.sv
// Shared fixed-point multiplier: registered full product, rounded half up.
// Depends on mgs_pkg.
`default_nettype none
module mgs_mul
  import mgs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [DW-1:0]     a,
  input  wire logic signed [DW-1:0]     b,
  output logic signed [PROD_W-1:0]      prod
);

  logic signed [2*DW-1:0] p_r;
  logic signed [2*DW-1:0] p_rnd;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p_rnd = p_r + (2*DW)'(64'sd1 <<< (FRAC_BITS - 1));
  assign prod  = PROD_W'(p_rnd >>> FRAC_BITS);

endmodule
`default_nettype wire

### hdl/mgs_rootdiv.sv
// Bit-serial unit for the integer square root and the unsigned division.
// Depends on mgs_pkg.
`default_nettype none
module mgs_rootdiv
  import mgs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rd_cmd_t           cmd,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [ROOT_W-1:0] den,
  output logic                   busy,
  output logic                   done,
  output logic [NUM_W-1:0]       res
);

  logic              busy_r;
  logic              done_r;
  logic              sq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]  v_r;
  logic [NUM_W-1:0]  q_r;
  logic [NUM_W-1:0]  b_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] den_r;
  logic [NUM_W:0]    sq_sum;
  logic [ROOT_W:0]   dv_t;

  assign sq_sum = {1'b0, q_r} + {1'b0, b_r};
  assign dv_t   = {rem_r[ROOT_W-1:0], v_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sq_r  <= cmd.is_sqrt;
      v_r   <= num;
      q_r   <= '0;
      b_r   <= NUM_W'(1) << (NUM_W - 2);
      rem_r <= '0;
      den_r <= den;
      cnt_r <= cmd.is_sqrt ? CNT_W'(ROOT_W - 1) : CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (sq_r) begin
        if ({1'b0, v_r} >= sq_sum) begin
          v_r <= v_r - sq_sum[NUM_W-1:0];
          q_r <= (q_r >> 1) + b_r;
        end else begin
          q_r <= q_r >> 1;
        end
        b_r <= b_r >> 2;
      end else begin
        v_r <= v_r << 1;
        if (dv_t >= {1'b0, den_r}) begin
          rem_r <= dv_t - {1'b0, den_r};
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= dv_t;
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = q_r;

endmodule
`default_nettype wire

### hdl/metric_gram_schmidt_core.sv
// Top level of the metric Gram-Schmidt core: stores, sequencer, config port.
// Depends on mgs_pkg, mgs_mul, mgs_rootdiv and assert_macros.svh.
//
//   Channel   Direction  Handshake             Carries
//   in_*      input      in_valid / in_stall   action, row, column, value
//   out_*     output     out_valid / out_stall data_real, data_imag, status
//   cfg       input      APB psel/penable      size_used, cols_used
//
// A write item's result is shown in the cycle after it is taken, and a read item's
// after the store is read in state ST_RD. The length of a run is set by the single
// shared multiplier and the bit-serial root and divide unit.
// Reset is synchronous; the stores hold no reset value.
// No new item is taken while an item is at work or its result waits.
`default_nettype none
module metric_gram_schmidt_core
  import mgs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic [4:0]           in_row,
  input  wire logic [4:0]           in_column,
  input  wire logic signed [31:0]   in_value_real,
  input  wire logic signed [31:0]   in_value_imag,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_data_real,
  output logic signed [31:0]        out_data_imag,
  output logic [1:0]                out_status,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

`include "assert_macros.svh"

  seq_state_t state_r, state_nxt;

  logic [5:0]       size_r;
  logic [4:0]       cols_r;
  logic [5:0]       n_r;
  logic [4:0]       m_r;
  logic             flag_r;
  logic             out_valid_r;
  logic [DW-1:0]    out_re_r, out_im_r;
  logic [1:0]       out_stat_r;

  logic [RA_W-1:0]  i_r, j_r;
  logic [CA_W-1:0]  c_r, p_r;
  logic [1:0]       k_r;
  logic             proj_r;

  cval_t            s_mem [MAX_ROWS*MAX_ROWS];
  cval_t            x_mem [MAX_ROWS*MAX_COLS];
  cval_t            s_q, x_q;
  cval_t            xp_r, sv_r, pr_r, xc_r;
  logic signed [DW-1:0]     qre_r;
  logic signed [ACC_W-1:0]  s_re_r, s_im_r, a_re_r, a_im_r;
  logic [ROOT_W-1:0]        root_r;
  acc_ctl_t                 acc_ctl_r;

  logic              in_acc, bad_in;
  action_t           act;
  logic              last_i, last_j, last_c;
  logic [CA_W-1:0]   c0;

  logic              s_we, s_ren, x_we, x_ren;
  logic [SA_W-1:0]   s_addr;
  logic [XA_W-1:0]   x_addr;
  cval_t             x_wdata, s_wdata;
  cval_t             op_a, op_b;
  logic signed [DW-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  acc_ctl_t          issue;
  rd_cmd_t           dv_cmd;
  logic [NUM_W-1:0]  dv_num;
  logic              dv_busy, dv_done;
  logic [NUM_W-1:0]  dv_res;
  sat_t              sat_sre, sat_sim, sat_are, sat_aim, dsat;
  logic              flag_set;
  logic signed [DW-1:0]     dcl, dv_x;
  logic [DW:0]       dv_mag;

  assign act      = action_t'(in_action);
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign bad_in   = (act == ACT_WR_S) ? (int'(in_row) >= MAX_ROWS || int'(in_column) >= MAX_ROWS)
                                      : (int'(in_row) >= MAX_ROWS || int'(in_column) >= MAX_COLS);

  assign last_i = ({1'b0, i_r} == 6'(n_r - 6'd1));
  assign last_j = ({1'b0, j_r} == 6'(n_r - 6'd1));
  assign last_c = ({1'b0, c_r} == 5'(m_r - 5'd1));
  assign c0     = proj_r ? p_r : c_r;

  assign sat_sre = sat_acc(s_re_r);
  assign sat_sim = sat_acc(s_im_r);
  assign sat_are = sat_acc(a_re_r);
  assign sat_aim = sat_acc(a_im_r);

  assign dv_x   = (state_r == ST_N_SRE || state_r == ST_N_WRE) ? xc_r.re : xc_r.im;
  assign dv_mag = dv_x[DW-1] ? -{dv_x[DW-1], dv_x} : {dv_x[DW-1], dv_x};
  assign dsat   = div_sat(dv_x[DW-1], dv_res);
  assign dcl    = (pr_r.re < 32'sd1) ? 32'sd1 : pr_r.re;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 6'(MAX_ROWS);
      cols_r <= 5'(MAX_COLS);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SIZE) begin
        size_r <= pwdata[5:0];
      end else begin
        cols_r <= pwdata[4:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_r) : 32'(size_r);
  assign pready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (act == ACT_RUN) begin
            state_nxt = ST_COL;
          end else if (act == ACT_RD_X && !bad_in) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD:     state_nxt = ST_IDLE;
      ST_COL:    state_nxt = ST_D_ROW;
      ST_D_ROW:  state_nxt = ST_D_RD;
      ST_D_RD:   state_nxt = ST_D_MUL;
      ST_D_MUL: begin
        if (k_r == 2'd3) begin
          state_nxt = last_j ? ST_D_DRN : ST_D_RD;
        end
      end
      ST_D_DRN:  state_nxt = ST_D_SAT;
      ST_D_SAT:  state_nxt = ST_D_OUT;
      ST_D_OUT: begin
        if (k_r == 2'd3) begin
          state_nxt = last_i ? ST_D_DRN2 : ST_D_ROW;
        end
      end
      ST_D_DRN2: state_nxt = ST_D_FIN;
      ST_D_FIN:  state_nxt = proj_r ? ST_U_RDP : ST_N_SQS;
      ST_U_RDP:  state_nxt = ST_U_RDC;
      ST_U_RDC:  state_nxt = ST_U_LD;
      ST_U_LD:   state_nxt = ST_U_MUL;
      ST_U_MUL: begin
        if (k_r == 2'd3) begin
          state_nxt = ST_U_DRN;
        end
      end
      ST_U_DRN:  state_nxt = ST_U_WR;
      ST_U_WR:   state_nxt = last_i ? ST_COL : ST_U_RDP;
      ST_N_SQS:  state_nxt = ST_N_SQW;
      ST_N_SQW: begin
        if (dv_done) begin
          state_nxt = ST_N_RD;
        end
      end
      ST_N_RD:   state_nxt = ST_N_LD;
      ST_N_LD:   state_nxt = ST_N_SRE;
      ST_N_SRE:  state_nxt = ST_N_WRE;
      ST_N_WRE: begin
        if (dv_done) begin
          state_nxt = ST_N_SIM;
        end
      end
      ST_N_SIM:  state_nxt = ST_N_WIM;
      ST_N_WIM: begin
        if (dv_done) begin
          state_nxt = !last_i ? ST_N_RD : (last_c ? ST_DONE : ST_COL);
        end
      end
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_we     = 1'b0;
    s_ren    = 1'b0;
    x_we     = 1'b0;
    x_ren    = 1'b0;
    s_addr   = {in_row[RA_W-1:0], in_column[RA_W-1:0]};
    x_addr   = {in_row[RA_W-1:0], in_column[CA_W-1:0]};
    s_wdata  = '{re: in_value_real, im: in_value_imag};
    x_wdata  = '{re: in_value_real, im: in_value_imag};
    op_a     = s_q;
    op_b     = x_q;
    issue    = '{valid: 1'b0, sel: ACC_S_RE, neg: 1'b0};
    dv_cmd   = '{start: 1'b0, is_sqrt: 1'b0};
    dv_num   = (NUM_W'(dv_mag) << FRAC_BITS) + NUM_W'(root_r >> 1);
    flag_set = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !bad_in) begin
          s_we  = (act == ACT_WR_S);
          x_we  = (act == ACT_WR_X);
          x_ren = (act == ACT_RD_X);
        end
      end
      ST_D_RD: begin
        s_ren  = 1'b1;
        x_ren  = 1'b1;
        s_addr = {i_r, j_r};
        x_addr = {j_r, c_r};
      end
      ST_D_MUL: begin
        issue.valid = 1'b1;
        issue.sel   = k_r[1] ? ACC_S_IM : ACC_S_RE;
        issue.neg   = (k_r == 2'd1);
      end
      ST_D_SAT: begin
        x_ren    = 1'b1;
        x_addr   = {i_r, c0};
        flag_set = sat_sre.ovf || sat_sim.ovf;
      end
      ST_D_OUT: begin
        op_a        = x_q;
        op_b        = sv_r;
        issue.valid = 1'b1;
        issue.sel   = k_r[1] ? ACC_A_IM : ACC_A_RE;
        issue.neg   = (k_r == 2'd3);
      end
      ST_D_FIN: begin
        flag_set = sat_are.ovf || sat_aim.ovf;
      end
      ST_U_RDP: begin
        x_ren  = 1'b1;
        x_addr = {i_r, p_r};
      end
      ST_U_RDC: begin
        x_ren  = 1'b1;
        x_addr = {i_r, c_r};
      end
      ST_U_MUL: begin
        op_a        = xp_r;
        op_b        = pr_r;
        issue.valid = 1'b1;
        issue.sel   = k_r[1] ? ACC_A_IM : ACC_A_RE;
        issue.neg   = (k_r != 2'd1);
      end
      ST_U_WR: begin
        x_we     = 1'b1;
        x_addr   = {i_r, c_r};
        x_wdata  = '{re: sat_are.val, im: sat_aim.val};
        flag_set = sat_are.ovf || sat_aim.ovf;
      end
      ST_N_SQS: begin
        dv_cmd = '{start: 1'b1, is_sqrt: 1'b1};
        dv_num = NUM_W'(unsigned'(dcl)) << FRAC_BITS;
      end
      ST_N_RD: begin
        x_ren  = 1'b1;
        x_addr = {i_r, c_r};
      end
      ST_N_SRE, ST_N_SIM: begin
        dv_cmd = '{start: 1'b1, is_sqrt: 1'b0};
      end
      ST_N_WRE: begin
        flag_set = dv_done && dsat.ovf;
      end
      ST_N_WIM: begin
        x_addr   = {i_r, c_r};
        x_wdata  = '{re: qre_r, im: dsat.val};
        x_we     = dv_done;
        flag_set = dv_done && dsat.ovf;
      end
      default: begin
      end
    endcase
    mul_a = k_r[0] ? op_a.im : op_a.re;
    mul_b = (k_r == 2'd0 || k_r == 2'd3) ? op_b.re : op_b.im;
  end

  // Stores.
  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_addr] <= s_wdata;
    end
    if (s_ren) begin
      s_q <= s_mem[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_addr] <= x_wdata;
    end
    if (x_ren) begin
      x_q <= x_mem[x_addr];
    end
  end

  mgs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mgs_rootdiv u_rootdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (dv_cmd),
    .num   (dv_num),
    .den   (root_r),
    .busy  (dv_busy),
    .done  (dv_done),
    .res   (dv_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_ctl_r   <= '{valid: 1'b0, sel: ACC_S_RE, neg: 1'b0};
    end else begin
      state_r   <= state_nxt;
      acc_ctl_r <= issue;
      if (in_acc && act == ACT_RUN) begin
        flag_r <= 1'b0;
      end else if (flag_set) begin
        flag_r <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end else if ((in_acc && !(act == ACT_RUN) && !(act == ACT_RD_X && !bad_in))
                   || state_r == ST_RD || state_r == ST_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      out_re_r   <= '0;
      out_im_r   <= '0;
      out_stat_r <= bad_in ? STAT_BAD : (flag_r ? STAT_SAT : STAT_OK);
    end else if (state_r == ST_RD) begin
      out_re_r   <= x_q.re;
      out_im_r   <= x_q.im;
      out_stat_r <= flag_r ? STAT_SAT : STAT_OK;
    end else if (state_r == ST_DONE) begin
      out_re_r   <= '0;
      out_im_r   <= '0;
      out_stat_r <= flag_r ? STAT_SAT : STAT_OK;
    end
  end

  // Loop counters and datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r <= (size_r == '0) ? 6'd1 : ((size_r > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : size_r);
        m_r <= (cols_r == '0) ? 5'd1 : ((cols_r > 5'(MAX_COLS)) ? 5'(MAX_COLS) : cols_r);
        c_r <= '0;
        p_r <= '0;
      end
      ST_COL: begin
        proj_r <= (p_r != c_r);
        i_r    <= '0;
      end
      ST_D_ROW: begin
        j_r <= '0;
        k_r <= '0;
      end
      ST_D_MUL: begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3 && !last_j) begin
          j_r <= j_r + RA_W'(1);
        end
      end
      ST_D_SAT: begin
        sv_r <= '{re: sat_sre.val, im: sat_sim.val};
        k_r  <= '0;
      end
      ST_D_OUT: begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3 && !last_i) begin
          i_r <= i_r + RA_W'(1);
        end
      end
      ST_D_FIN: begin
        pr_r <= '{re: sat_are.val, im: sat_aim.val};
        i_r  <= '0;
      end
      ST_U_RDC: begin
        xp_r <= x_q;
        k_r  <= '0;
      end
      ST_U_MUL: begin
        k_r <= k_r + 2'd1;
      end
      ST_U_WR: begin
        if (last_i) begin
          p_r <= p_r + CA_W'(1);
        end else begin
          i_r <= i_r + RA_W'(1);
        end
      end
      ST_N_SQW: begin
        if (dv_done) begin
          root_r <= dv_res[ROOT_W-1:0];
        end
      end
      ST_N_LD: begin
        xc_r <= x_q;
      end
      ST_N_WRE: begin
        if (dv_done) begin
          qre_r <= dsat.val;
        end
      end
      ST_N_WIM: begin
        if (dv_done) begin
          if (!last_i) begin
            i_r <= i_r + RA_W'(1);
          end else begin
            c_r <= c_r + CA_W'(1);
            p_r <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Accumulators: inner metric-vector sum and outer dot / update sum.
  always_ff @(posedge clk) begin
    if (state_r == ST_COL) begin
      a_re_r <= '0;
      a_im_r <= '0;
    end else if (state_r == ST_U_LD) begin
      a_re_r <= ACC_W'(x_q.re);
      a_im_r <= ACC_W'(x_q.im);
    end
    if (state_r == ST_D_ROW) begin
      s_re_r <= '0;
      s_im_r <= '0;
    end
    if (acc_ctl_r.valid) begin
      case (acc_ctl_r.sel)
        ACC_S_RE: s_re_r <= acc_ctl_r.neg ? s_re_r - ACC_W'(prod) : s_re_r + ACC_W'(prod);
        ACC_S_IM: s_im_r <= acc_ctl_r.neg ? s_im_r - ACC_W'(prod) : s_im_r + ACC_W'(prod);
        ACC_A_RE: a_re_r <= acc_ctl_r.neg ? a_re_r - ACC_W'(prod) : a_re_r + ACC_W'(prod);
        ACC_A_IM: a_im_r <= acc_ctl_r.neg ? a_im_r - ACC_W'(prod) : a_im_r + ACC_W'(prod);
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_real = out_re_r;
  assign out_data_imag = out_im_r;
  assign out_status    = out_stat_r;

  `MGS_ASSERT_IMP(a_no_acc_in_idle, clk, rst_n, acc_ctl_r.valid, state_r != ST_IDLE)
  `MGS_ASSERT_IMP(a_div_only_norm, clk, rst_n, dv_busy,
    state_r == ST_N_SQW || state_r == ST_N_WRE || state_r == ST_N_WIM)
  `MGS_ASSERT_NXT(a_run_clears_flag, clk, rst_n, in_acc && act == ACT_RUN, !flag_r)

endmodule
`default_nettype wire
